// ===== rtl/jsr_pkg.sv =====
// Shared types, codes and helper functions of the JSON stream reformatter.
package jsr_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } jsr_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
    logic [1:0] status;
  } jsr_out_t;

  // Parser modes
  localparam logic [3:0] M_VALUE = 4'd0;
  localparam logic [3:0] M_ELEM  = 4'd1;
  localparam logic [3:0] M_COLON = 4'd2;
  localparam logic [3:0] M_AFTER = 4'd3;
  localparam logic [3:0] M_SKEY  = 4'd4;
  localparam logic [3:0] M_SVAL  = 4'd5;
  localparam logic [3:0] M_LIT   = 4'd6;
  localparam logic [3:0] M_NUM   = 4'd7;
  localparam logic [3:0] M_ERR   = 4'd8;

  // Number phases
  localparam logic [2:0] P_SIGN  = 3'd0;
  localparam logic [2:0] P_ZERO  = 3'd1;
  localparam logic [2:0] P_INT   = 3'd2;
  localparam logic [2:0] P_DOT   = 3'd3;
  localparam logic [2:0] P_FRAC  = 3'd4;
  localparam logic [2:0] P_EXP   = 3'd5;
  localparam logic [2:0] P_ESIGN = 3'd6;
  localparam logic [2:0] P_EXPD  = 3'd7;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SYNTAX = 2'd1;
  localparam logic [1:0] ST_DEEP  = 2'd2;

  // Command kinds handed from the front to the back
  localparam logic [2:0] C_NONE  = 3'd0;  // nothing to emit
  localparam logic [2:0] C_ONE   = 3'd1;  // one raw byte
  localparam logic [2:0] C_PAIR  = 3'd2;  // two bytes (a then b)
  localparam logic [2:0] C_CP    = 3'd3;  // code point, UTF-8 plus re-escape

  localparam int unsigned CMD_NB_W = 4;

  // Command word: up to 8 result bytes already expanded, plus terminal flag.
  typedef struct packed {
    logic [7:0][7:0] bytes;
    logic [CMD_NB_W-1:0] count;   // number of data bytes, 0..6 as issued
    logic             term;       // append terminal result
    logic [1:0]       status;
  } jsr_cmd_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic [4:0] hexval(input logic [7:0] b);
    // bit 4 set marks a non-hex byte
    if (b >= 8'h30 && b <= 8'h39) return {1'b0, 4'(b - 8'h30)};
    if (b >= 8'h61 && b <= 8'h66) return {1'b0, 4'(b - 8'h57)};
    if (b >= 8'h41 && b <= 8'h46) return {1'b0, 4'(b - 8'h37)};
    return 5'h10;
  endfunction

  function automatic logic [7:0] hex_lower(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h57 + {4'd0, n});
  endfunction

  function automatic logic [7:0] lit_char(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0:  c = "t";
      4'd1:  c = "r";
      4'd2:  c = "u";
      4'd3:  c = "e";
      4'd4:  c = "f";
      4'd5:  c = "a";
      4'd6:  c = "l";
      4'd7:  c = "s";
      4'd8:  c = "e";
      4'd9:  c = "n";
      4'd10: c = "u";
      4'd11: c = "l";
      4'd12: c = "l";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/json_stream_reformatter.sv =====
// Top level of the JSON stream reformatter: parser, command queue and serializer.
// The block takes one JSON byte per cycle and re-serializes it: whitespace
// outside strings is dropped, separators become ", " and ": ", strings are
// decoded (\u escapes, surrogate pairs) to UTF-8 and re-escaped. The parser
// accepts a byte every cycle while its command queue has room; each byte
// becomes one queue entry holding 0 to 6 output words plus, on in_last, a
// terminal word (out_valid 0, out_last 1, status). The serializer sends one
// word per cycle while out_ready is high, so throughput is one byte per cycle
// for bytes that emit one word or none; the four-entry queue absorbs the
// output of expanding bytes. Status on the terminal word is 0 ok,
// 1 syntax error or incomplete document, 2 nesting deeper than MAX_DEPTH.
// After an error the rest of the document is discarded; after the
// terminal word the block starts fresh. No clearing pass is needed at reset.
module json_stream_reformatter #(
  parameter int MAX_DEPTH = 32,
  parameter int Q_DEPTH   = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  jsr_pkg::jsr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output jsr_pkg::jsr_out_t out_data
);
  import jsr_pkg::*;

  // Level counter must hold MAX_DEPTH itself
  localparam int LVL_W = $clog2(MAX_DEPTH + 1);

  jsr_cmd_t cmd, q_data;
  logic     q_full, q_empty, q_pop;
  logic     step;

  // Accept a word whenever the queue has room
  assign in_ready = !q_full;
  assign step     = in_valid && in_ready;

  jsr_front #(.MAX_DEPTH(MAX_DEPTH), .LVL_W(LVL_W)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_word (in_data),
    .cmd     (cmd)
  );

  jsr_queue #(.DEPTH(Q_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (step),
    .wr_data (cmd),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  jsr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid_o (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_data)
  );

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("queue underflow");

  // A full queue must refuse input
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !in_ready) else $error("accept while queue full");

  // Terminal word never carries a data byte
  a_term_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.out_last) |-> !out_data.out_valid)
    else $error("terminal word flagged as data");

endmodule

// ===== rtl/jsr_front.sv =====
// Front end: parses one byte per cycle on step, issues an expanded command.
module jsr_front #(
  parameter int MAX_DEPTH = 32,
  parameter int LVL_W     = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,        // a byte is accepted this cycle
  input  jsr_pkg::jsr_in_t  in_word,
  output jsr_pkg::jsr_cmd_t cmd
);
  import jsr_pkg::*;

  localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic [3:0]       mode_r, mode_nxt;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  logic             first_r, first_nxt;
  logic [3:0]       esc_r, esc_nxt;
  logic [15:0]      hex_r, hex_nxt;
  logic [9:0]       hs_r, hs_nxt;
  logic [3:0]       lit_r, lit_nxt;
  logic [2:0]       num_r, num_nxt;
  logic [1:0]       err_r, err_nxt;

  // Kind stack: flops, valid only below lvl_r
  logic [MAX_DEPTH-1:0] kinds_r;
  logic                 push_en;
  logic                 push_kind;

  logic [7:0] b;
  logic       last;
  logic       top_kind;
  logic       lvl_ok;
  logic [2:0] kind;
  logic [7:0] ka, kb;
  logic [20:0] cp;
  logic [4:0] hv;
  logic [15:0] hacc;
  logic [2:0] nnext;
  logic       nvalid;
  logic       ncomplete;
  logic       mode_after;   // pass byte to after-value logic
  logic [3:0] endmode;
  logic [1:0] st;

  assign b    = in_word.in_byte;
  assign last = in_word.in_last;
  assign lvl_ok = (lvl_r != '0) && (lvl_r <= LVL_W'(MAX_DEPTH));
  assign top_kind = lvl_ok ? kinds_r[IDX_W'(lvl_r - 1'b1)] : 1'b0;
  assign hv   = hexval(b);
  assign hacc = {hex_r[11:0], hv[3:0]};

  // Number grammar step
  always_comb begin
    nnext  = P_SIGN;
    nvalid = 1'b0;
    case (num_r)
      P_SIGN: if (is_digit(b)) begin
        nvalid = 1'b1; nnext = (b == "0") ? P_ZERO : P_INT;
      end
      P_ZERO: if (b == ".") begin
        nvalid = 1'b1; nnext = P_DOT;
      end else if (b == "e" || b == "E") begin
        nvalid = 1'b1; nnext = P_EXP;
      end
      P_INT: if (is_digit(b)) begin
        nvalid = 1'b1; nnext = P_INT;
      end else if (b == ".") begin
        nvalid = 1'b1; nnext = P_DOT;
      end else if (b == "e" || b == "E") begin
        nvalid = 1'b1; nnext = P_EXP;
      end
      P_DOT: if (is_digit(b)) begin
        nvalid = 1'b1; nnext = P_FRAC;
      end
      P_FRAC: if (is_digit(b)) begin
        nvalid = 1'b1; nnext = P_FRAC;
      end else if (b == "e" || b == "E") begin
        nvalid = 1'b1; nnext = P_EXP;
      end
      P_EXP: if (b == "+" || b == "-") begin
        nvalid = 1'b1; nnext = P_ESIGN;
      end else if (is_digit(b)) begin
        nvalid = 1'b1; nnext = P_EXPD;
      end
      default: if (is_digit(b)) begin
        nvalid = 1'b1; nnext = P_EXPD;
      end
    endcase
  end
  assign ncomplete = (num_r == P_ZERO) || (num_r == P_INT) ||
                     (num_r == P_FRAC) || (num_r == P_EXPD);

  // Main parse step
  always_comb begin
    mode_nxt  = mode_r;
    lvl_nxt   = lvl_r;
    first_nxt = first_r;
    esc_nxt   = esc_r;
    hex_nxt   = hex_r;
    hs_nxt    = hs_r;
    lit_nxt   = lit_r;
    num_nxt   = num_r;
    err_nxt   = err_r;
    push_en   = 1'b0;
    push_kind = 1'b0;
    kind      = C_NONE;
    ka        = 8'h00;
    kb        = 8'h00;
    cp        = '0;
    mode_after = 1'b0;

    case (mode_r)
      M_VALUE, M_ELEM: begin
        if (!is_ws(b)) begin
          if (mode_r == M_ELEM && lvl_ok && first_r &&
              ((b == "]" && !top_kind) || (b == "}" && top_kind))) begin
            kind = C_ONE; ka = b;
            lvl_nxt = lvl_r - 1'b1;
            mode_nxt = M_AFTER;
          end else if (mode_r == M_ELEM && lvl_ok && top_kind) begin
            if (b == 8'h22) begin
              kind = C_ONE; ka = b; esc_nxt = 4'd0; mode_nxt = M_SKEY;
            end else begin
              err_nxt = ST_SYNTAX; mode_nxt = M_ERR;
            end
          end else if (b == 8'h22) begin
            kind = C_ONE; ka = b; esc_nxt = 4'd0; mode_nxt = M_SVAL;
          end else if (b == "{" || b == "[") begin
            if (lvl_r >= LVL_W'(MAX_DEPTH)) begin
              err_nxt = ST_DEEP; mode_nxt = M_ERR;
            end else begin
              push_en = 1'b1; push_kind = (b == "{");
              lvl_nxt = lvl_r + 1'b1;
              first_nxt = 1'b1;
              mode_nxt = M_ELEM;
              kind = C_ONE; ka = b;
            end
          end else if (b == "t" || b == "f" || b == "n") begin
            lit_nxt = (b == "t") ? 4'd1 : (b == "f") ? 4'd5 : 4'd10;
            mode_nxt = M_LIT;
            kind = C_ONE; ka = b;
          end else if (b == "-" || is_digit(b)) begin
            num_nxt = (b == "-") ? P_SIGN : (b == "0") ? P_ZERO : P_INT;
            mode_nxt = M_NUM;
            kind = C_ONE; ka = b;
          end else begin
            err_nxt = ST_SYNTAX; mode_nxt = M_ERR;
          end
        end
      end
      M_COLON: begin
        if (!is_ws(b)) begin
          if (b == ":") begin
            kind = C_PAIR; ka = ":"; kb = " "; mode_nxt = M_VALUE;
          end else begin
            err_nxt = ST_SYNTAX; mode_nxt = M_ERR;
          end
        end
      end
      M_AFTER: mode_after = 1'b1;
      M_SKEY, M_SVAL: begin
        if (esc_r == 4'd0) begin
          if (b == 8'h22) begin
            kind = C_ONE; ka = b;
            mode_nxt = (mode_r == M_SKEY) ? M_COLON : M_AFTER;
          end else if (b == 8'h5C) begin
            esc_nxt = 4'd1;
          end else if (b < 8'h20) begin
            err_nxt = ST_SYNTAX; mode_nxt = M_ERR;
          end else begin
            kind = C_ONE; ka = b;
          end
        end else if (esc_r == 4'd1) begin
          esc_nxt = 4'd0;
          case (b)
            8'h22, 8'h5C, "b", "f", "n", "r", "t": begin
              kind = C_PAIR; ka = 8'h5C; kb = b;
            end
            "/": begin
              kind = C_ONE; ka = b;
            end
            "u": begin
              esc_nxt = 4'd2; hex_nxt = 16'h0;
            end
            default: begin
              err_nxt = ST_SYNTAX; mode_nxt = M_ERR;
            end
          endcase
        end else if (esc_r == 4'd6) begin
          if (b == 8'h5C) esc_nxt = 4'd7;
          else begin
            err_nxt = ST_SYNTAX; mode_nxt = M_ERR;
          end
        end else if (esc_r == 4'd7) begin
          if (b == "u") begin
            esc_nxt = 4'd8; hex_nxt = 16'h0;
          end else begin
            err_nxt = ST_SYNTAX; mode_nxt = M_ERR;
          end
        end else if (esc_r > 4'd11 || hv[4]) begin
          err_nxt = ST_SYNTAX; mode_nxt = M_ERR;
        end else begin
          hex_nxt = hacc;
          esc_nxt = esc_r + 4'd1;
          if (esc_r == 4'd5) begin
            if (hacc >= 16'hD800 && hacc <= 16'hDBFF) begin
              hs_nxt = 10'(hacc - 16'hD800);
            end else if (hacc >= 16'hDC00) begin
              if (hacc <= 16'hDFFF) begin
                err_nxt = ST_SYNTAX; mode_nxt = M_ERR;
              end else begin
                kind = C_CP; cp = {5'd0, hacc}; esc_nxt = 4'd0;
              end
            end else begin
              kind = C_CP; cp = {5'd0, hacc}; esc_nxt = 4'd0;
            end
          end else if (esc_r == 4'd11) begin
            if (hacc < 16'hDC00 || hacc > 16'hDFFF) begin
              err_nxt = ST_SYNTAX; mode_nxt = M_ERR;
            end else begin
              kind = C_CP;
              cp = 21'h10000 + {1'b0, hs_r, hacc[9:0]};
              esc_nxt = 4'd0;
            end
          end
        end
      end
      M_LIT: begin
        if (lit_r == 4'd0 || lit_r > 4'd12 || b != lit_char(lit_r)) begin
          err_nxt = ST_SYNTAX; mode_nxt = M_ERR;
        end else begin
          kind = C_ONE; ka = b;
          lit_nxt = lit_r + 4'd1;
          if (lit_r == 4'd3 || lit_r == 4'd8 || lit_r == 4'd12) begin
            lit_nxt = 4'd0; mode_nxt = M_AFTER;
          end
        end
      end
      M_NUM: begin
        if (!ncomplete && !nvalid) begin
          err_nxt = ST_SYNTAX; mode_nxt = M_ERR;
        end else if (num_r == P_ZERO && is_digit(b)) begin
          err_nxt = ST_SYNTAX; mode_nxt = M_ERR;
        end else if (nvalid) begin
          num_nxt = nnext; kind = C_ONE; ka = b;
        end else begin
          mode_nxt = M_AFTER; mode_after = 1'b1;
        end
      end
      default: ;
    endcase

    // After a value: comma, closer or whitespace
    if (mode_after && !is_ws(b)) begin
      if (lvl_r == '0) begin
        err_nxt = ST_SYNTAX; mode_nxt = M_ERR;
      end else if (b == ",") begin
        kind = C_PAIR; ka = ","; kb = " ";
        first_nxt = 1'b0; mode_nxt = M_ELEM;
      end else if (lvl_ok && ((b == "]" && !top_kind) || (b == "}" && top_kind))) begin
        kind = C_ONE; ka = b;
        lvl_nxt = lvl_r - 1'b1; mode_nxt = M_AFTER;
      end else begin
        err_nxt = ST_SYNTAX; mode_nxt = M_ERR;
      end
    end
  end

  // Terminal status
  always_comb begin
    endmode = mode_nxt;
    if (mode_nxt == M_NUM && (num_nxt == P_ZERO || num_nxt == P_INT ||
        num_nxt == P_FRAC || num_nxt == P_EXPD))
      endmode = M_AFTER;
    if (err_nxt != ST_OK) st = err_nxt;
    else if (endmode == M_AFTER && lvl_nxt == '0) st = ST_OK;
    else st = ST_SYNTAX;
  end

  // Expand the command into bytes
  always_comb begin
    logic [7:0] eb;
    eb = 8'h00;
    cmd = '0;
    cmd.term = last;
    cmd.status = last ? st : ST_OK;
    case (kind)
      C_ONE: begin
        cmd.bytes[0] = ka; cmd.count = 4'd1;
      end
      C_PAIR: begin
        cmd.bytes[0] = ka; cmd.bytes[1] = kb; cmd.count = 4'd2;
      end
      C_CP: begin
        if (cp < 21'h80) begin
          eb = cp[7:0];
          case (eb)
            8'h22, 8'h5C: begin
              cmd.bytes[0] = 8'h5C; cmd.bytes[1] = eb; cmd.count = 4'd2;
            end
            8'h08: begin
              cmd.bytes[0] = 8'h5C; cmd.bytes[1] = "b"; cmd.count = 4'd2;
            end
            8'h0C: begin
              cmd.bytes[0] = 8'h5C; cmd.bytes[1] = "f"; cmd.count = 4'd2;
            end
            8'h0A: begin
              cmd.bytes[0] = 8'h5C; cmd.bytes[1] = "n"; cmd.count = 4'd2;
            end
            8'h0D: begin
              cmd.bytes[0] = 8'h5C; cmd.bytes[1] = "r"; cmd.count = 4'd2;
            end
            8'h09: begin
              cmd.bytes[0] = 8'h5C; cmd.bytes[1] = "t"; cmd.count = 4'd2;
            end
            default: begin
              if (eb < 8'h20) begin
                cmd.bytes[0] = 8'h5C; cmd.bytes[1] = "u";
                cmd.bytes[2] = "0";   cmd.bytes[3] = "0";
                cmd.bytes[4] = hex_lower(eb[7:4]);
                cmd.bytes[5] = hex_lower(eb[3:0]);
                cmd.count = 4'd6;
              end else begin
                cmd.bytes[0] = eb; cmd.count = 4'd1;
              end
            end
          endcase
        end else if (cp < 21'h800) begin
          cmd.bytes[0] = 8'hC0 | {3'd0, cp[10:6]};
          cmd.bytes[1] = 8'h80 | {2'd0, cp[5:0]};
          cmd.count = 4'd2;
        end else if (cp < 21'h10000) begin
          cmd.bytes[0] = 8'hE0 | {4'd0, cp[15:12]};
          cmd.bytes[1] = 8'h80 | {2'd0, cp[11:6]};
          cmd.bytes[2] = 8'h80 | {2'd0, cp[5:0]};
          cmd.count = 4'd3;
        end else begin
          cmd.bytes[0] = 8'hF0 | {5'd0, cp[20:18]};
          cmd.bytes[1] = 8'h80 | {2'd0, cp[17:12]};
          cmd.bytes[2] = 8'h80 | {2'd0, cp[11:6]};
          cmd.bytes[3] = 8'h80 | {2'd0, cp[5:0]};
          cmd.count = 4'd4;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_VALUE;
      lvl_r   <= '0;
      first_r <= 1'b1;
      esc_r   <= 4'd0;
      hex_r   <= 16'h0;
      hs_r    <= 10'h0;
      lit_r   <= 4'd0;
      num_r   <= P_SIGN;
      err_r   <= ST_OK;
    end else if (step) begin
      if (last) begin
        mode_r  <= M_VALUE;
        lvl_r   <= '0;
        first_r <= 1'b1;
        esc_r   <= 4'd0;
        hex_r   <= 16'h0;
        hs_r    <= 10'h0;
        lit_r   <= 4'd0;
        num_r   <= P_SIGN;
        err_r   <= ST_OK;
      end else begin
        mode_r  <= mode_nxt;
        lvl_r   <= lvl_nxt;
        first_r <= first_nxt;
        esc_r   <= esc_nxt;
        hex_r   <= hex_nxt;
        hs_r    <= hs_nxt;
        lit_r   <= lit_nxt;
        num_r   <= num_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && push_en) kinds_r[IDX_W'(lvl_r)] <= push_kind;
  end

endmodule

// ===== rtl/jsr_queue.sv =====
// Short command queue between the parser and the serializer.
module jsr_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  jsr_pkg::jsr_cmd_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output jsr_pkg::jsr_cmd_t rd_data,
  output logic              empty
);
  import jsr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  jsr_cmd_t      mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full    = (cnt_r == (PW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == PW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd_en) rp_r <= (rp_r == PW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(wr_en) - (PW+1)'(rd_en);
    end
  end

endmodule

// ===== rtl/jsr_back.sv =====
// Back end: walks command bytes to a register, one word per cycle while not stalled.
module jsr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  jsr_pkg::jsr_cmd_t q_data,
  output logic              q_pop,
  output logic              out_valid_o,
  input  logic              out_ready,
  output jsr_pkg::jsr_out_t out_word
);
  import jsr_pkg::*;

  logic [CMD_NB_W-1:0] idx_r;
  logic                v_r;
  jsr_out_t            data_r;
  logic                load;
  logic                have;
  logic                is_term;
  logic                at_end;

  // Current entry produces: bytes idx<count, then term if set.
  assign have    = !q_empty && ((idx_r < q_data.count) || q_data.term);
  assign is_term = (idx_r >= q_data.count);
  assign load    = (!v_r || out_ready) && have;
  assign at_end  = is_term || (idx_r + 1'b1 == q_data.count && !q_data.term);
  // Drop empty commands, pop when the last word of a command loads.
  assign q_pop   = !q_empty && ((!have) || (load && at_end));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      idx_r <= '0;
    end else begin
      if (load) v_r <= 1'b1;
      else if (out_ready) v_r <= 1'b0;
      if (q_pop) idx_r <= '0;
      else if (load) idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (is_term) begin
        data_r.out_byte  <= 8'h00;
        data_r.out_valid <= 1'b0;
        data_r.out_last  <= 1'b1;
        data_r.status    <= q_data.status;
      end else begin
        data_r.out_byte  <= q_data.bytes[idx_r[2:0]];
        data_r.out_valid <= 1'b1;
        data_r.out_last  <= 1'b0;
        data_r.status    <= ST_OK;
      end
    end
  end

  assign out_valid_o = v_r;
  assign out_word    = data_r;

endmodule
